// File: rtl/fbf_pkg.sv
// ----------------------------------------------------------------------------
// fbf_pkg
// Shared widths, register indexes and beat payload types for the
// Fischer-Burmeister function block.
// ----------------------------------------------------------------------------
package fbf_pkg;

  localparam int InW      = 24;
  localparam int FracBits = 16;
  localparam int ResW     = 26;
  localparam int GradW    = 19;
  localparam int SqW      = 2 * InW;
  localparam int RootW    = InW;
  localparam int RemW     = InW + 2;
  localparam int DRemW    = InW + 1;
  localparam int QW       = FracBits + 1;
  localparam int IdxW     = 8;
  localparam int CfgDW    = 8;

  localparam logic [IdxW-1:0] RegAIsLe = IdxW'(0);
  localparam logic [IdxW-1:0] RegBIsLe = IdxW'(1);

  typedef struct packed {
    logic signed [InW-1:0] a;
    logic signed [InW-1:0] b;
    logic [SqW-1:0]        pa;
    logic [SqW-1:0]        pb;
  } sq_t;

  typedef struct packed {
    logic signed [InW-1:0] a;
    logic signed [InW-1:0] b;
    logic [SqW-1:0]        x;
    logic [RemW-1:0]       rem;
    logic [RootW-1:0]      root;
  } rt_t;

  typedef struct packed {
    logic signed [InW-1:0] a;
    logic signed [InW-1:0] b;
    logic [RootW-1:0]      r;
    logic [DRemW-1:0]      rem_a;
    logic [DRemW-1:0]      rem_b;
    logic [QW-1:0]         q_a;
    logic [QW-1:0]         q_b;
  } dv_t;

endpackage

// File: rtl/fbf_if.sv
// ----------------------------------------------------------------------------
// fbf channel interfaces
// Valid/ready channels for operand beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface fbf_in_if;
  import fbf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [InW-1:0] a_val;
  logic signed [InW-1:0] b_val;
  modport source (output valid, a_val, b_val, input ready);
  modport sink   (input valid, a_val, b_val, output ready);
endinterface

interface fbf_out_if;
  import fbf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ResW-1:0]  residual;
  logic signed [GradW-1:0] grad_a;
  logic signed [GradW-1:0] grad_b;
  modport source (output valid, residual, grad_a, grad_b, input ready);
  modport sink   (input valid, residual, grad_a, grad_b, output ready);
endinterface

interface fbf_cfg_if;
  import fbf_pkg::*;
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  index;
  logic [CfgDW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/fbf_sq_cell.sv
// ----------------------------------------------------------------------------
// fbf_sq_cell
// Entry cell: registers the squared magnitudes of both operands.
// ----------------------------------------------------------------------------
module fbf_sq_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [fbf_pkg::InW-1:0] a_i,
  input  logic signed [fbf_pkg::InW-1:0] b_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output fbf_pkg::sq_t                   data_o
);
  import fbf_pkg::*;

  logic           valid_q;
  sq_t            data_d, data_q;
  logic [InW-1:0] ma, mb;

  assign ready_o = !valid_q || ready_i;
  assign ma = a_i[InW-1] ? (~a_i + InW'(1)) : a_i;
  assign mb = b_i[InW-1] ? (~b_i + InW'(1)) : b_i;

  always_comb begin
    data_d.a  = a_i;
    data_d.b  = b_i;
    data_d.pa = ma * ma;
    data_d.pb = mb * mb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/fbf_sqrt_cell.sv
// ----------------------------------------------------------------------------
// fbf_sqrt_cell
// One digit of the restoring square root: settles one root bit per cell.
// ----------------------------------------------------------------------------
module fbf_sqrt_cell #(
  parameter int Pos = 0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  fbf_pkg::rt_t data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output fbf_pkg::rt_t data_o
);
  import fbf_pkg::*;

  logic            valid_q;
  rt_t             data_d, data_q;
  logic [RemW-1:0] rem2, trial;
  logic            ge;

  assign ready_o = !valid_q || ready_i;
  assign rem2    = {data_i.rem[RemW-3:0], data_i.x[2*Pos+1 -: 2]};
  assign trial   = {data_i.root, 2'b01};
  assign ge      = rem2 >= trial;

  always_comb begin
    data_d      = data_i;
    data_d.rem  = ge ? (rem2 - trial) : rem2;
    data_d.root = {data_i.root[RootW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/fbf_div_cell.sv
// ----------------------------------------------------------------------------
// fbf_div_cell
// One quotient bit of both magnitude divisions |a|/r and |b|/r.
// ----------------------------------------------------------------------------
module fbf_div_cell #(
  parameter bit Shift = 1'b1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  fbf_pkg::dv_t data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output fbf_pkg::dv_t data_o
);
  import fbf_pkg::*;

  logic             valid_q;
  dv_t              data_d, data_q;
  logic [DRemW-1:0] sa, sb, rx;
  logic             ga, gb;

  assign ready_o = !valid_q || ready_i;
  assign rx = {1'b0, data_i.r};
  // first cell takes the integer quotient bit, no shift
  assign sa = Shift ? {data_i.rem_a[DRemW-2:0], 1'b0} : data_i.rem_a;
  assign sb = Shift ? {data_i.rem_b[DRemW-2:0], 1'b0} : data_i.rem_b;
  assign ga = sa >= rx;
  assign gb = sb >= rx;

  always_comb begin
    data_d       = data_i;
    data_d.rem_a = ga ? (sa - rx) : sa;
    data_d.rem_b = gb ? (sb - rx) : sb;
    data_d.q_a   = {data_i.q_a[QW-2:0], ga};
    data_d.q_b   = {data_i.q_b[QW-2:0], gb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/fbf_out_cell.sv
// ----------------------------------------------------------------------------
// fbf_out_cell
// Final cell: applies the signs and registers residual and both gradients.
// ----------------------------------------------------------------------------
module fbf_out_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             a_is_le_i,
  input  logic                             b_is_le_i,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  fbf_pkg::dv_t                     data_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic signed [fbf_pkg::ResW-1:0]  residual_o,
  output logic signed [fbf_pkg::GradW-1:0] grad_a_o,
  output logic signed [fbf_pkg::GradW-1:0] grad_b_o
);
  import fbf_pkg::*;

  localparam logic signed [GradW-1:0] One = GradW'(1) <<< FracBits;

  logic                    valid_q;
  logic signed [ResW-1:0]  ae, be, re, res_d, res_q;
  logic signed [GradW-1:0] s_a, s_b, qa, qb, ga_d, gb_d, ga_q, gb_q;
  logic                    rz;

  assign ready_o = !valid_q || ready_i;
  assign ae  = ResW'(data_i.a);
  assign be  = ResW'(data_i.b);
  assign re  = $signed({{(ResW-RootW){1'b0}}, data_i.r});
  assign res_d = (a_is_le_i ? -ae : ae) + (b_is_le_i ? -be : be) - re;
  assign s_a = a_is_le_i ? -One : One;
  assign s_b = b_is_le_i ? -One : One;
  assign qa  = $signed({{(GradW-QW){1'b0}}, data_i.q_a});
  assign qb  = $signed({{(GradW-QW){1'b0}}, data_i.q_b});
  assign rz  = data_i.r == '0;
  assign ga_d = rz ? s_a : (data_i.a[InW-1] ? s_a + qa : s_a - qa);
  assign gb_d = rz ? s_b : (data_i.b[InW-1] ? s_b + qb : s_b - qb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
      ga_q  <= ga_d;
      gb_q  <= gb_d;
    end
  end

  assign valid_o    = valid_q;
  assign residual_o = res_q;
  assign grad_a_o   = ga_q;
  assign grad_b_o   = gb_q;

endmodule

// File: rtl/fischer_burmeister_function_top.sv
// Pipeline: 1 square, 24 root, 17 divide and 1 output cell from operand beat to result beat.
// Throughput: one beat per cycle while out_o is ready; every cell is a pipeline stage with its own valid bit.
// The rate is set by the row of cells, each passing its beat on once the next has room.
// Reset: rst_ni clears all valid bits and both sign registers (sign +1).
// ----------------------------------------------------------------------------
// fischer_burmeister_function_top
// Fischer-Burmeister residual and gradients as a chain of bit-level cells.
// ----------------------------------------------------------------------------
module fischer_burmeister_function_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  fbf_in_if.sink    in_i,
  fbf_cfg_if.sink   cfg_i,
  fbf_out_if.source out_o
);
  import fbf_pkg::*;

  localparam int NRoot = RootW;
  localparam int NDiv  = QW;

  logic a_le_q, b_le_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_le_q <= 1'b0;
      b_le_q <= 1'b0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == RegAIsLe) a_le_q <= cfg_i.data[0];
      if (cfg_i.index == RegBIsLe) b_le_q <= cfg_i.data[0];
    end
  end

  sq_t  sq_d;
  logic sq_v, sq_r;

  fbf_sq_cell u_sq (
    .clk_i, .rst_ni,
    .valid_i (in_i.valid), .ready_o (in_i.ready),
    .a_i (in_i.a_val), .b_i (in_i.b_val),
    .valid_o (sq_v), .ready_i (sq_r), .data_o (sq_d)
  );

  rt_t  rt_d [NRoot+1];
  logic rt_v [NRoot+1];
  logic rt_r [NRoot+1];

  always_comb begin
    rt_d[0].a    = sq_d.a;
    rt_d[0].b    = sq_d.b;
    rt_d[0].x    = sq_d.pa + sq_d.pb;
    rt_d[0].rem  = '0;
    rt_d[0].root = '0;
  end
  assign rt_v[0] = sq_v;
  assign sq_r    = rt_r[0];

  for (genvar k = 0; k < NRoot; k++) begin : g_root
    fbf_sqrt_cell #(.Pos(NRoot-1-k)) u_cell (
      .clk_i, .rst_ni,
      .valid_i (rt_v[k]), .ready_o (rt_r[k]), .data_i (rt_d[k]),
      .valid_o (rt_v[k+1]), .ready_i (rt_r[k+1]), .data_o (rt_d[k+1])
    );
  end

  dv_t  dv_d [NDiv+1];
  logic dv_v [NDiv+1];
  logic dv_r [NDiv+1];

  always_comb begin
    dv_d[0].a     = rt_d[NRoot].a;
    dv_d[0].b     = rt_d[NRoot].b;
    dv_d[0].r     = rt_d[NRoot].root;
    dv_d[0].rem_a = {1'b0, (rt_d[NRoot].a[InW-1] ? ~rt_d[NRoot].a + InW'(1) : rt_d[NRoot].a)};
    dv_d[0].rem_b = {1'b0, (rt_d[NRoot].b[InW-1] ? ~rt_d[NRoot].b + InW'(1) : rt_d[NRoot].b)};
    dv_d[0].q_a   = '0;
    dv_d[0].q_b   = '0;
  end
  assign dv_v[0]      = rt_v[NRoot];
  assign rt_r[NRoot]  = dv_r[0];

  for (genvar k = 0; k < NDiv; k++) begin : g_div
    fbf_div_cell #(.Shift(k != 0)) u_cell (
      .clk_i, .rst_ni,
      .valid_i (dv_v[k]), .ready_o (dv_r[k]), .data_i (dv_d[k]),
      .valid_o (dv_v[k+1]), .ready_i (dv_r[k+1]), .data_o (dv_d[k+1])
    );
  end

  fbf_out_cell u_out (
    .clk_i, .rst_ni,
    .a_is_le_i (a_le_q), .b_is_le_i (b_le_q),
    .valid_i (dv_v[NDiv]), .ready_o (dv_r[NDiv]), .data_i (dv_d[NDiv]),
    .valid_o (out_o.valid), .ready_i (out_o.ready),
    .residual_o (out_o.residual), .grad_a_o (out_o.grad_a), .grad_b_o (out_o.grad_b)
  );

`ifndef SYNTHESIS
  // root never falls below either operand magnitude
  a_root_ge_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v[0] |-> ({1'b0, dv_d[0].r} >= dv_d[0].rem_a) && ({1'b0, dv_d[0].r} >= dv_d[0].rem_b))
    else $error("root below operand magnitude");

  // quotient of a magnitude by the root stays within 1.0 (zero root gives no quotient)
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v[NDiv] && (dv_d[NDiv].r != '0)) |->
      (dv_d[NDiv].q_a <= (QW'(1) << FracBits)) &&
      (dv_d[NDiv].q_b <= (QW'(1) << FracBits)))
    else $error("quotient above one");

  // gradients lie within two units
  a_grad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.grad_a <= 131072) && (out_o.grad_a >= -131072) &&
                    (out_o.grad_b <= 131072) && (out_o.grad_b >= -131072))
    else $error("gradient out of range");
`endif

endmodule

// File: tb/sv/tb_fischer_burmeister_function_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fischer_burmeister_function_top
// Streams operand beats through the Fischer-Burmeister block under several
// sign settings and compares each result beat with a local prediction.
// ----------------------------------------------------------------------------
module tb_fischer_burmeister_function_top;
  import fbf_pkg::*;

  localparam int Latency  = 43;
  localparam int MaxCycle = 400000;
  localparam int HoldLen  = 200;

  typedef struct packed {
    logic signed [InW-1:0] a;
    logic signed [InW-1:0] b;
  } operands_t;

  typedef struct packed {
    logic signed [ResW-1:0]  residual;
    logic signed [GradW-1:0] grad_a;
    logic signed [GradW-1:0] grad_b;
  } fb_result_t;

  logic clk_i;
  logic rst_ni;

  fbf_in_if  in_if ();
  fbf_out_if out_if ();
  fbf_cfg_if cfg_if ();

  fischer_burmeister_function_top i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .cfg_i (cfg_if.sink),
    .out_o (out_if.source)
  );

  operands_t  pending_ops[$];
  fb_result_t expected_fb[$];
  logic       a_le, b_le;
  int         n_errors;
  int         cycle_cnt;
  int         send_idle_pct, recv_idle_pct;
  int         hold_cycles;
  bit         hold_req;
  bit         pause_send;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [RootW-1:0] floor_root(logic [SqW-1:0] x);
    logic [SqW-1:0] res;
    logic [SqW-1:0] bitv;
    res  = '0;
    bitv = SqW'(1) << (SqW - 2);
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[RootW-1:0];
  endfunction

  function automatic logic signed [GradW-1:0] fb_grad(logic le, logic signed [InW-1:0] v,
                                                      logic [RootW-1:0] r);
    longint one, s, q, mv;
    one = longint'(1) << FracBits;
    s   = le ? -one : one;
    if (r == 0) return GradW'(s);
    mv = (v < 0) ? -longint'(v) : longint'(v);
    q  = (mv << FracBits) / longint'(r);
    return GradW'((v < 0) ? s + q : s - q);
  endfunction

  function automatic fb_result_t fb_predict(operands_t op);
    fb_result_t       res;
    longint           ma, mb, sum;
    logic [RootW-1:0] r;
    ma  = (op.a < 0) ? -longint'(op.a) : longint'(op.a);
    mb  = (op.b < 0) ? -longint'(op.b) : longint'(op.b);
    r   = floor_root(SqW'(ma * ma + mb * mb));
    sum = (a_le ? -longint'(op.a) : longint'(op.a))
        + (b_le ? -longint'(op.b) : longint'(op.b)) - longint'(r);
    res.residual = ResW'(sum);
    res.grad_a   = fb_grad(a_le, op.a, r);
    res.grad_b   = fb_grad(b_le, op.b, r);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_v);
    $display("mismatch %s: got %0d expected %0d", what, got, exp_v);
    n_errors++;
  endtask

  // driver: predicts on acceptance, then offers the next pending beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.a_val <= '0;
      in_if.b_val <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_fb.push_back(fb_predict(operands_t'({in_if.a_val, in_if.b_val})));
        void'(pending_ops.pop_front());
      end
      if ((in_if.valid && !in_if.ready) ||
          (pending_ops.size() > 0 && !pause_send &&
           $urandom_range(99) >= send_idle_pct)) begin
        operands_t nxt;
        nxt = pending_ops[0];
        in_if.valid <= 1'b1;
        in_if.a_val <= nxt.a;
        in_if.b_val <= nxt.b;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver hold-off counter
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cycles <= 0;
    end else if (hold_req && hold_cycles == 0) begin
      hold_cycles <= HoldLen;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      cycle_cnt    <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > MaxCycle) begin
        $display("** fischer_burmeister_function_top: FAILED **");
        $finish;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_fb.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          fb_result_t e;
          e = expected_fb.pop_front();
          if (out_if.residual !== e.residual)
            report_mismatch("residual", out_if.residual, e.residual);
          if (out_if.grad_a !== e.grad_a) report_mismatch("grad_a", out_if.grad_a, e.grad_a);
          if (out_if.grad_b !== e.grad_b) report_mismatch("grad_b", out_if.grad_b, e.grad_b);
        end
      end
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgDW-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == RegAIsLe) a_le = val[0];
    else if (idx == RegBIsLe) b_le = val[0];
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || in_if.valid || expected_fb.size() != 0)
      @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic signed [InW-1:0] rand_operand();
    case ($urandom_range(5))
      0: return InW'($urandom_range(255)) - 128;
      1: return {1'b0, {(InW-1){1'b1}}} - InW'($urandom_range(3));
      2: return {1'b1, {(InW-1){1'b0}}} + InW'($urandom_range(3));
      3: return '0;
      default: return InW'($urandom);
    endcase
  endfunction

  task automatic push_random(int n);
    repeat (n) pending_ops.push_back(operands_t'({rand_operand(), rand_operand()}));
  endtask

  initial begin
    logic signed [InW-1:0] corner[5];
    clk_i         = 1'b0;
    n_errors      = 0;
    a_le          = 1'b0;
    b_le          = 1'b0;
    pause_send    = 1'b0;
    hold_req      = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 76;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    rst_ni        = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero pair, extremes, signs, single-bit values
    corner = '{24'sh800000, 24'sh7fffff, 24'sh000000, 24'sh000001, 24'shffffff};
    foreach (corner[i]) foreach (corner[j])
      pending_ops.push_back(operands_t'({corner[i], corner[j]}));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(RegAIsLe, CfgDW'($urandom) & 8'hfe | CfgDW'(ph[0]));
      write_reg(RegBIsLe, CfgDW'($urandom) & 8'hfe | CfgDW'(ph[1]));
      if (ph == 2) begin
        send_idle_pct = 76;
        recv_idle_pct = 8;
      end else if (ph == 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      push_random(90);
      if (ph == 1) begin
        // long receiver hold-off so the pipeline backs up
        hold_req = 1'b1;
        wait (hold_cycles > 0);
        hold_req = 1'b0;
      end
      drain();
    end
    // register index outside the map must be ignored
    write_reg(IdxW'(5), 8'hff);
    pause_send = 1'b1;
    push_random(20);
    repeat (30) @(posedge clk_i);
    pause_send = 1'b0;
    drain();

    if (n_errors == 0) begin
      $display("** fischer_burmeister_function_top: PASSED **");
    end else begin
      $display("** fischer_burmeister_function_top: FAILED **");
    end
    $finish;
  end

endmodule
